>>> rtl/core/rbsi_pkg.sv
// rbsi_pkg: payload structs, divider stage types and register indexes for the
// ray versus box slab test; no dependencies
package rbsi_pkg;

    localparam int unsigned COORD_W   = 32;
    localparam int unsigned SIDE_W    = 31;
    localparam int unsigned EPS_W     = 16;
    localparam int unsigned NUM_W     = 35;  // signed twice-numerator
    localparam int unsigned NUM_MAG_W = 34;  // its magnitude
    localparam int unsigned DVS_W     = 33;  // |2*d|
    localparam int unsigned DIV_STEPS = 32;  // quotient bits, one per stage
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_LENGTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON     = 8'd1;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 31'd131072;
    localparam logic [EPS_W-1:0]  EPS_RESET  = 16'd66;

    localparam logic signed [COORD_W-1:0] T_POS_INF = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] T_NEG_INF = 32'sh8000_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
    } ray_in_t;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] t_near;
        logic signed [COORD_W-1:0] t_far;
    } ray_out_t;

    typedef struct packed {
        logic parallel;
        logic num_pos;
        logic num_zero;
        logic q_neg;
        logic ovf;
        logic is_exit;
    } slab_flags_t;

    typedef struct packed {
        logic [DVS_W-1:0]   rem;
        logic [COORD_W-1:0] xlow;
        logic [DVS_W-1:0]   dvs;
        slab_flags_t        flags;
    } div_in_t;

endpackage

>>> rtl/core/rbsi_slab_div.sv
// rbsi_slab_div: pipelined restoring divider for one slab distance, one
// quotient bit per stage, with saturation on the way out; uses rbsi_pkg
module rbsi_slab_div (
    input  logic                                  aclk,
    input  logic [rbsi_pkg::DIV_STEPS-1:0]        adv,
    input  rbsi_pkg::div_in_t                     din,
    output logic signed [rbsi_pkg::COORD_W-1:0]   t_out
);
    import rbsi_pkg::*;

    logic [DVS_W-1:0]    rem_reg  [DIV_STEPS];
    logic [COORD_W-1:0]  xl_reg   [DIV_STEPS];
    logic [COORD_W-1:0]  q_reg    [DIV_STEPS];
    logic [DVS_W-1:0]    dvs_reg  [DIV_STEPS];
    slab_flags_t         flg_reg  [DIV_STEPS];

    logic [DVS_W-1:0]    rem_next [DIV_STEPS];
    logic [COORD_W-1:0]  xl_next  [DIV_STEPS];
    logic [COORD_W-1:0]  q_next   [DIV_STEPS];
    logic [DVS_W-1:0]    dvs_next [DIV_STEPS];
    slab_flags_t         flg_next [DIV_STEPS];

    always_comb begin
        logic [DVS_W-1:0]   r_p;
        logic [COORD_W-1:0] x_p;
        logic [COORD_W-1:0] q_p;
        logic [DVS_W-1:0]   d_p;
        slab_flags_t        f_p;
        logic [DVS_W:0]     trial;
        logic               ge;
        for (int j = 0; j < DIV_STEPS; j++) begin
            if (j == 0) begin
                r_p = din.rem;
                x_p = din.xlow;
                q_p = '0;
                d_p = din.dvs;
                f_p = din.flags;
            end else begin
                r_p = rem_reg[j-1];
                x_p = xl_reg[j-1];
                q_p = q_reg[j-1];
                d_p = dvs_reg[j-1];
                f_p = flg_reg[j-1];
            end
            trial       = {r_p, x_p[COORD_W-1]};
            ge          = trial >= {1'b0, d_p};
            rem_next[j] = ge ? DVS_W'(trial - {1'b0, d_p}) : trial[DVS_W-1:0];
            xl_next[j]  = {x_p[COORD_W-2:0], 1'b0};
            q_next[j]   = {q_p[COORD_W-2:0], ge};
            dvs_next[j] = d_p;
            flg_next[j] = f_p;
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < DIV_STEPS; j++) begin
            if (adv[j]) begin
                rem_reg[j] <= rem_next[j];
                xl_reg[j]  <= xl_next[j];
                q_reg[j]   <= q_next[j];
                dvs_reg[j] <= dvs_next[j];
                flg_reg[j] <= flg_next[j];
            end
        end
    end

    // saturate and sign the last stage
    always_comb begin
        slab_flags_t        fl;
        logic [COORD_W-1:0] q;
        fl = flg_reg[DIV_STEPS-1];
        q  = q_reg[DIV_STEPS-1];
        if (fl.parallel) begin
            if (fl.num_pos) begin
                t_out = T_POS_INF;
            end else if (!fl.num_zero) begin
                t_out = T_NEG_INF;
            end else begin
                t_out = fl.is_exit ? T_POS_INF : T_NEG_INF;
            end
        end else if (fl.ovf) begin
            t_out = fl.q_neg ? T_NEG_INF : T_POS_INF;
        end else if (fl.q_neg) begin
            t_out = q[COORD_W-1] ? T_NEG_INF : -$signed(q);
        end else begin
            t_out = q[COORD_W-1] ? T_POS_INF : $signed(q);
        end
    end

endmodule

>>> rtl/core/ray_box_slab_intersect.sv
// ray_box_slab_intersect: top level of the ray versus cube slab test
// depends on rbsi_pkg and rbsi_slab_div
//
// One ray item enters per cycle while s_ready is high and passes through one
// prepare stage, a 32-stage divider (one quotient bit per stage, six dividers
// side by side for the entry and exit of each axis), then sort, min/max and
// hit stages. Empty stages close up while the result side stalls, so items
// keep flowing in until the pipeline is full. Configuration writes are always
// taken and must only be issued while the pipeline holds no item.
module ray_box_slab_intersect #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  rbsi_pkg::ray_in_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output rbsi_pkg::ray_out_t                  m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rbsi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rbsi_pkg::CFG_DAT_W-1:0]      cfg_data
);
    import rbsi_pkg::*;

    localparam int unsigned XW  = NUM_MAG_W + FRAC_BITS;
    localparam int unsigned HW  = XW - COORD_W;
    localparam int unsigned NST = DIV_STEPS + 4;
    localparam int unsigned S_SORT = DIV_STEPS + 1;
    localparam int unsigned S_MM   = DIV_STEPS + 2;
    localparam int unsigned S_OUT  = DIV_STEPS + 3;

    logic [SIDE_W-1:0] side_reg;
    logic [EPS_W-1:0]  eps_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= SIDE_RESET;
            eps_reg  <= EPS_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SIDE_LENGTH: side_reg <= cfg_data[SIDE_W-1:0];
                CFG_EPSILON:     eps_reg  <= cfg_data[EPS_W-1:0];
                default: ;
            endcase
        end
    end

    // stage valids and advance chain
    logic [NST-1:0] v_reg;
    logic [NST-1:0] adv;

    always_comb begin
        adv[NST-1] = !v_reg[NST-1] || m_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign s_ready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (adv[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // prepare: numerators, magnitudes, parallel and overflow flags
    logic signed [COORD_W-1:0] org [3];
    logic signed [COORD_W-1:0] dir [3];
    div_in_t prep_next [6];
    div_in_t prep_reg  [6];

    assign org[0] = s_data.origin_x;
    assign org[1] = s_data.origin_y;
    assign org[2] = s_data.origin_z;
    assign dir[0] = s_data.dir_x;
    assign dir[1] = s_data.dir_y;
    assign dir[2] = s_data.dir_z;

    always_comb begin
        logic signed [NUM_W-1:0] side_e;
        logic signed [NUM_W-1:0] o2;
        logic signed [NUM_W-1:0] num;
        logic [NUM_MAG_W-1:0]    nmag;
        logic [XW-1:0]           x;
        logic [COORD_W-1:0]      dmag;
        logic [DVS_W-1:0]        dvs;
        logic                    par;
        side_e = $signed({{(NUM_W - SIDE_W){1'b0}}, side_reg});
        for (int a = 0; a < 3; a++) begin
            o2   = $signed({{(NUM_W - COORD_W - 1){org[a][COORD_W-1]}}, org[a], 1'b0});
            dmag = dir[a][COORD_W-1] ? COORD_W'(-dir[a]) : dir[a];
            dvs  = {dmag, 1'b0};
            par  = (dmag == '0) || (dmag < {{(COORD_W - EPS_W){1'b0}}, eps_reg});
            for (int e = 0; e < 2; e++) begin
                num  = (e == 0) ? (-side_e - o2) : (side_e - o2);
                nmag = num[NUM_W-1] ? NUM_MAG_W'(-num) : num[NUM_MAG_W-1:0];
                x    = {nmag, {FRAC_BITS{1'b0}}};
                prep_next[2*a+e].rem  = {{(DVS_W - HW){1'b0}}, x[XW-1:COORD_W]};
                prep_next[2*a+e].xlow = x[COORD_W-1:0];
                prep_next[2*a+e].dvs  = dvs;
                prep_next[2*a+e].flags.parallel = par;
                prep_next[2*a+e].flags.num_pos  = !num[NUM_W-1] && (num != '0);
                prep_next[2*a+e].flags.num_zero = (num == '0);
                prep_next[2*a+e].flags.q_neg    = num[NUM_W-1] ^ dir[a][COORD_W-1];
                // quotient would need more than 32 bits
                prep_next[2*a+e].flags.ovf      =
                    {{(DVS_W - HW){1'b0}}, x[XW-1:COORD_W]} >= dvs;
                prep_next[2*a+e].flags.is_exit  = (e == 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            for (int i = 0; i < 6; i++) begin
                prep_reg[i] <= prep_next[i];
            end
        end
    end

    logic signed [COORD_W-1:0] t_div [6];

    for (genvar g = 0; g < 6; g++) begin : g_div
        rbsi_slab_div u_div (
            .aclk  (aclk),
            .adv   (adv[DIV_STEPS:1]),
            .din   (prep_reg[g]),
            .t_out (t_div[g])
        );
    end

    // per-axis sort
    logic signed [COORD_W-1:0] lo_reg [3];
    logic signed [COORD_W-1:0] hi_reg [3];

    always_ff @(posedge aclk) begin
        if (adv[S_SORT]) begin
            for (int a = 0; a < 3; a++) begin
                if (t_div[2*a] > t_div[2*a+1]) begin
                    lo_reg[a] <= t_div[2*a+1];
                    hi_reg[a] <= t_div[2*a];
                end else begin
                    lo_reg[a] <= t_div[2*a];
                    hi_reg[a] <= t_div[2*a+1];
                end
            end
        end
    end

    // largest entry, smallest exit
    logic signed [COORD_W-1:0] near_reg, far_reg;
    logic signed [COORD_W-1:0] near_next, far_next;

    always_comb begin
        near_next = lo_reg[0];
        far_next  = hi_reg[0];
        for (int a = 1; a < 3; a++) begin
            if (lo_reg[a] > near_next) begin
                near_next = lo_reg[a];
            end
            if (hi_reg[a] < far_next) begin
                far_next = hi_reg[a];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[S_MM]) begin
            near_reg <= near_next;
            far_reg  <= far_next;
        end
    end

    ray_out_t out_reg;

    always_ff @(posedge aclk) begin
        if (adv[S_OUT]) begin
            out_reg.hit    <= (near_reg <= far_reg);
            out_reg.t_near <= near_reg;
            out_reg.t_far  <= far_reg;
        end
    end

    assign m_valid = v_reg[S_OUT];
    assign m_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_hit_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.hit == (m_data.t_near <= m_data.t_far)))
        else $error("hit flag disagrees with near and far");

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v_reg[0])
        else $error("accepted item did not enter the prepare stage");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (v_reg == '0))
        else $error("pipeline not empty after reset");

    a_stall_holds_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[S_OUT] && !m_ready) |-> !adv[S_OUT])
        else $error("output stage advanced while stalled");
`endif

endmodule

>>> sim/tb_top.sv
// tb_top: self-checking testbench for ray_box_slab_intersect
// depends on rbsi_pkg and the ray_box_slab_intersect rtl
`timescale 1ns / 100ps

class slab_scoreboard;
    rbsi_pkg::ray_out_t pending_hits[$];
    int unsigned        mismatches;
    logic [30:0]        side_q;
    logic [15:0]        eps_q;

    function new();
        mismatches = 0;
        side_q     = rbsi_pkg::SIDE_RESET;
        eps_q      = rbsi_pkg::EPS_RESET;
    endfunction

    // entry/exit for one slab, wide signed math then saturation
    function automatic longint slab_t(longint o, longint d, bit is_exit, bit par);
        longint num2;
        longint q;
        num2 = (is_exit ? longint'(side_q) : -longint'(side_q)) - 2 * o;
        if (par) begin
            if (num2 > 0) return 64'sd2147483647;
            if (num2 < 0) return -64'sd2147483648;
            return is_exit ? 64'sd2147483647 : -64'sd2147483648;
        end
        q = (num2 * 65536) / (2 * d);
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q;
    endfunction

    function void note_ray(rbsi_pkg::ray_in_t r);
        longint o[3];
        longint d[3];
        longint t0, t1, tn, tf, mag;
        bit par;
        rbsi_pkg::ray_out_t e;
        o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
        d[0] = r.dir_x;    d[1] = r.dir_y;    d[2] = r.dir_z;
        tn = -64'sd2147483648;
        tf = 64'sd2147483647;
        for (int a = 0; a < 3; a++) begin
            mag = d[a] < 0 ? -d[a] : d[a];
            par = (d[a] == 0) || (mag < longint'(eps_q));
            t0 = slab_t(o[a], d[a], 1'b0, par);
            t1 = slab_t(o[a], d[a], 1'b1, par);
            if (t0 > t1) begin
                mag = t0; t0 = t1; t1 = mag;
            end
            if (a == 0 || t0 > tn) tn = t0;
            if (a == 0 || t1 < tf) tf = t1;
        end
        e.hit    = (tn <= tf);
        e.t_near = tn[31:0];
        e.t_far  = tf[31:0];
        pending_hits.push_back(e);
    endfunction

    function void check_result(rbsi_pkg::ray_out_t got);
        rbsi_pkg::ray_out_t e;
        if (pending_hits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
        end
        e = pending_hits.pop_front();
        if (got.hit !== e.hit || got.t_near !== e.t_near || got.t_far !== e.t_far) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch exp hit=%b near=%h far=%h got hit=%b near=%h far=%h",
                         e.hit, e.t_near, e.t_far, got.hit, got.t_near, got.t_far);
        end
    endfunction
endclass

module tb_top;
    import rbsi_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    ray_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    ray_out_t    m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    slab_scoreboard sb = new();
    bit             rx_on = 1'b0;

    ray_box_slab_intersect u_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned gap_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: random stalls, check on each accepted item
    always @(posedge aclk) begin
        if (m_valid && m_ready) sb.check_result(m_data);
    end
    initial begin
        int unsigned g;
        forever begin
            @(posedge aclk);
            if (rx_on) begin
                g = gap_len();
                if (g == 0) m_ready <= 1'b1;
                else begin
                    m_ready <= 1'b0;
                    repeat (g - 1) @(posedge aclk);
                end
            end
        end
    end

    // valid stays high into the next item when there is no gap
    task automatic send_ray(ray_in_t r);
        cfg_valid <= 1'b0;
        s_valid   <= 1'b1;
        s_data    <= r;
        do @(posedge aclk); while (!s_ready);
        sb.note_ray(r);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_SIDE_LENGTH) sb.side_q = val[30:0];
        else sb.eps_q = val[15:0];
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_hits.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 200)) - 100);
            default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
        endcase
    endfunction

    function automatic ray_in_t rnd_ray();
        ray_in_t r;
        r.origin_x = rnd_coord(); r.origin_y = rnd_coord(); r.origin_z = rnd_coord();
        r.dir_x = rnd_coord(); r.dir_y = rnd_coord(); r.dir_z = rnd_coord();
        if ($urandom_range(0, 9) == 0) r.dir_y = 0;
        return r;
    endfunction

    task automatic random_rays(int n);
        int unsigned g;
        for (int i = 0; i < n; i++) begin
            send_ray(rnd_ray());
            g = gap_len();
            if (g != 0) begin
                s_valid <= 1'b0;
                repeat (g) @(posedge aclk);
            end
        end
    endtask

    initial begin
        ray_in_t r;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        rx_on = 1'b1;
        // directed: axis rays, parallel rays, zero numerator, extremes
        r = '{origin_x: -32'sh0005_0000, origin_y: 0, origin_z: 0,
              dir_x: 32'sh0001_0000, dir_y: 0, dir_z: 0};
        send_ray(r);
        r.origin_y = 32'sh0001_0000;  // on the face, parallel: zero numerator
        send_ray(r);
        r.origin_y = 32'sh0003_0000;  // parallel outside the slab
        send_ray(r);
        r.dir_y = 65; send_ray(r);    // below epsilon
        r.dir_y = 66; send_ray(r);    // at epsilon
        r.dir_y = -66; send_ray(r);
        r = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000};
        send_ray(r);
        r = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0042};
        send_ray(r);
        r = '{0, 0, 0, 0, 0, 0}; send_ray(r);
        r = '{0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}; send_ray(r);
        r = '{32'h0000_8000, 32'hFFFF_8000, 0, 32'hFFFF_0000, 32'h0001_0000, 32'h1234};
        send_ray(r);
        random_rays(140);
        drain();
        write_reg(CFG_SIDE_LENGTH, 32'h7FFF_FFFF);
        write_reg(CFG_EPSILON, 32'h0000_FFFF);
        random_rays(100);
        drain();
        write_reg(CFG_SIDE_LENGTH, 32'h0);
        write_reg(CFG_EPSILON, 32'h0);
        r = '{0, 0, 0, 0, 32'h0001_0000, 32'h0000_0001}; send_ray(r);
        random_rays(100);
        drain();
        write_reg(CFG_SIDE_LENGTH, 32'h8000_0001);  // upper bit dropped
        write_reg(CFG_EPSILON, 32'hFFFF_0100);
        random_rays(100);
        drain();
        write_reg(CFG_SIDE_LENGTH, $urandom);
        write_reg(CFG_EPSILON, $urandom_range(0, 65535));
        random_rays(100);
        drain();
        if (sb.mismatches == 0 && sb.pending_hits.size() == 0)
            $display("ray_box_slab_intersect verification clean");
        else
            $display("ray_box_slab_intersect verification failed");
        $finish;
    end

    initial begin
        #2ms;
        $display("ray_box_slab_intersect verification failed");
        $finish;
    end
endmodule
